// File: rtl/core/largest_fit_quantum_scheduler_top_macros.svh
// assertion macros for the largest-fit quantum scheduler
// used by largest_fit_quantum_scheduler_top; no other dependencies
`ifndef LARGEST_FIT_QUANTUM_SCHEDULER_TOP_MACROS_SVH
`define LARGEST_FIT_QUANTUM_SCHEDULER_TOP_MACROS_SVH

// check on every edge while out of reset
`define LFQS_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// check on every edge, reset included
`define LFQS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: rtl/core/lfqs_pkg.sv
// shared widths, codes and the result row type of the quantum scheduler
// no dependencies; used by every module of the block but lfqs_ram
package lfqs_pkg;

  // input item fields
  localparam int SLOT_W     = 4;
  localparam int LEN_W      = 6;
  localparam int QNT_W      = 6;
  localparam int IN_TDATA_W = 16;

  // configuration
  localparam int NUM_W = 5;
  localparam logic [NUM_W-1:0] NUM_PROC_RESET = 5'd16;

  // result item fields
  localparam int PN_W        = 5;
  localparam int PT_W        = 6;
  localparam int BUD_W       = 7;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (PN_W + PT_W + 2 * BUD_W + 1);

  localparam logic [BUD_W-1:0] BUDGET_MAX = 7'd127;

  // item kinds carried on in_tuser
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_QUANTUM = 1'b1;

  // one result row
  typedef struct packed {
    logic             selected;
    logic [PN_W-1:0]  process_number;
    logic [PT_W-1:0]  process_time;
    logic [BUD_W-1:0] budget;
    logic [BUD_W-1:0] remaining;
    logic             last;
    logic             all_done;
  } lfqs_row_t;

endpackage

// File: rtl/core/lfqs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lfqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lfqs_sched.sv
// scheduling engine: load handling, per-pick table scan, finished flags, budget
// depends on lfqs_pkg; drives the run time ram through its memory port
module lfqs_sched #(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [lfqs_pkg::SLOT_W-1:0]       in_slot,
  input  logic [lfqs_pkg::LEN_W-1:0]        in_run_length,
  input  logic [lfqs_pkg::QNT_W-1:0]        in_quantum,
  // register write
  input  logic                              cfg_valid,
  input  logic [lfqs_pkg::NUM_W-1:0]        cfg_data,
  // run time ram
  output logic                              mem_we,
  output logic [$clog2(MAX_PROCESSES)-1:0]  mem_waddr,
  output logic [TIME_BITS-1:0]              mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(MAX_PROCESSES)-1:0]  mem_raddr,
  input  logic [TIME_BITS-1:0]              mem_rdata,
  // result rows
  output logic                              row_valid,
  input  logic                              row_ready,
  output lfqs_pkg::lfqs_row_t               row
);

  localparam int IDXW  = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int CMP_W = (TIME_BITS > lfqs_pkg::BUD_W) ? TIME_BITS : lfqs_pkg::BUD_W;
  localparam int PNX_W = IDXW + 1;
  localparam int SUM_W = lfqs_pkg::BUD_W + 1;
  localparam logic [CNT_W-1:0] N_RESET =
    (MAX_PROCESSES < int'(lfqs_pkg::NUM_PROC_RESET)) ? CNT_W'(MAX_PROCESSES)
                                                    : CNT_W'(lfqs_pkg::NUM_PROC_RESET);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            a_r, a_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [IDXW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [TIME_BITS-1:0]        best_r, best_nxt;
  logic [IDXW-1:0]             pick_r, pick_nxt;
  logic                        found_r, found_nxt;
  logic [lfqs_pkg::BUD_W-1:0]  budget_r, budget_nxt;
  logic [lfqs_pkg::BUD_W-1:0]  carry_r, carry_nxt;
  logic [MAX_PROCESSES-1:0]    fin_r, fin_nxt;
  logic [CNT_W-1:0]            n_act_r, n_act_nxt;

  logic [MAX_PROCESSES-1:0]    act_mask;
  logic [MAX_PROCESSES-1:0]    pend_vec;
  logic [MAX_PROCESSES-1:0]    pick_oh;
  logic [SUM_W-1:0]            budget_sum;
  logic [lfqs_pkg::BUD_W-1:0]  budget_sat;
  logic [lfqs_pkg::BUD_W-1:0]  after;
  logic [PNX_W-1:0]            pick_num;
  logic                        slot_ok;
  logic                        cand;
  logic                        done_sel;
  logic                        done_idle;
  logic                        stop;

  // entries below the active count take part
  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      act_mask[i] = (CNT_W'(i) < n_act_r);
    end
  end

  // quantum added to the carried budget, saturating
  assign budget_sum = SUM_W'(carry_r) + SUM_W'(in_quantum);
  assign budget_sat = (budget_sum > SUM_W'(lfqs_pkg::BUDGET_MAX)) ? lfqs_pkg::BUDGET_MAX
                                                                 : budget_sum[lfqs_pkg::BUD_W-1:0];

  assign slot_ok = (32'(in_slot) < MAX_PROCESSES);

  // candidate test on the entry just read
  assign cand = rd_vld_r && !fin_r[rd_idx_r] && (mem_rdata != '0) &&
                (CMP_W'(mem_rdata) <= CMP_W'(budget_r)) && (mem_rdata > best_r);

  // pick outcome
  assign pend_vec  = ~fin_r & act_mask;
  assign pick_oh   = MAX_PROCESSES'(1) << pick_r;
  assign done_sel  = ~|(pend_vec & ~pick_oh);
  assign done_idle = ~|pend_vec;
  assign after     = lfqs_pkg::BUD_W'(CMP_W'(budget_r) - CMP_W'(best_r));
  assign stop      = (after == '0) || done_sel;
  assign pick_num  = PNX_W'(pick_r) + PNX_W'(1);

  // result row for the emit state
  always_comb begin
    row.selected       = found_r;
    row.process_number = found_r ? lfqs_pkg::PN_W'(pick_num) : '0;
    row.process_time   = found_r ? lfqs_pkg::PT_W'(best_r) : '0;
    row.budget         = budget_r;
    row.remaining      = found_r ? after : budget_r;
    row.last           = found_r ? stop : 1'b1;
    row.all_done       = found_r ? done_sel : done_idle;
  end

  // sequencer: load, scan, emit
  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    best_nxt   = best_r;
    pick_nxt   = pick_r;
    found_nxt  = found_r;
    budget_nxt = budget_r;
    carry_nxt  = carry_r;
    fin_nxt    = fin_r;
    n_act_nxt  = n_act_r;
    mem_we     = 1'b0;
    mem_waddr  = IDXW'(in_slot);
    mem_wdata  = TIME_BITS'(in_run_length);
    mem_re     = 1'b0;
    mem_raddr  = a_r[IDXW-1:0];
    row_valid  = 1'b0;
    in_ready   = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == lfqs_pkg::FUNC_LOAD) begin
            if (slot_ok) begin
              mem_we                   = 1'b1;
              fin_nxt[IDXW'(in_slot)]  = 1'b0;
            end
          end else begin
            budget_nxt = budget_sat;
            a_nxt      = '0;
            best_nxt   = '0;
            pick_nxt   = '0;
            found_nxt  = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read a cycle
        if (a_r < n_act_r) begin
          mem_re     = 1'b1;
          a_nxt      = a_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = a_r[IDXW-1:0];
        end
        // keep the longest fitting entry, first one wins on ties
        if (cand) begin
          best_nxt  = mem_rdata;
          pick_nxt  = rd_idx_r;
          found_nxt = 1'b1;
        end
        if (!(a_r < n_act_r) && !rd_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        row_valid = 1'b1;
        if (row_ready) begin
          if (found_r) begin
            fin_nxt[pick_r] = 1'b1;
            if (stop) begin
              carry_nxt = '0;
              state_nxt = ST_IDLE;
            end else begin
              budget_nxt = after;
              a_nxt      = '0;
              best_nxt   = '0;
              pick_nxt   = '0;
              found_nxt  = 1'b0;
              state_nxt  = ST_SCAN;
            end
          end else begin
            carry_nxt = budget_r;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write, clamped to the table size
    if (cfg_valid) begin
      n_act_nxt = (32'(cfg_data) > MAX_PROCESSES) ? CNT_W'(MAX_PROCESSES) : CNT_W'(cfg_data);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
      fin_r    <= '0;
      carry_r  <= '0;
      n_act_r  <= N_RESET;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      fin_r    <= fin_nxt;
      carry_r  <= carry_nxt;
      n_act_r  <= n_act_nxt;
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    rd_idx_r <= rd_idx_nxt;
    best_r   <= best_nxt;
    pick_r   <= pick_nxt;
    found_r  <= found_nxt;
    budget_r <= budget_nxt;
  end

endmodule

// File: rtl/core/lfqs_outreg.sv
// output holding register: stores one result row and packs it onto the stream
// depends on lfqs_pkg
module lfqs_outreg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                row_valid,
  output logic                                row_ready,
  input  lfqs_pkg::lfqs_row_t                 row,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // process_number, process_time, budget, remaining, all_done, zero pad
  output logic [lfqs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // selected
  output logic                                out_tuser,
  output logic                                out_tlast
);

  logic                vld_r;
  lfqs_pkg::lfqs_row_t row_r;

  // slot is free when empty or being drained
  assign row_ready = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (row_ready) begin
      vld_r <= row_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (row_ready && row_valid) begin
      row_r <= row;
    end
  end

  // stream packing
  assign out_tvalid = vld_r;
  assign out_tdata  = {{lfqs_pkg::OUT_PAD_W{1'b0}}, row_r.all_done, row_r.remaining,
                       row_r.budget, row_r.process_time, row_r.process_number};
  assign out_tuser  = row_r.selected;
  assign out_tlast  = row_r.last;

endmodule

// File: rtl/core/largest_fit_quantum_scheduler_top.sv
// Largest-fit quantum scheduler. A load item (in_tuser = 0) writes one run time into
// the table. A quantum item (in_tuser = 1) is turned into result rows: each row costs
// one scan of the active table through the single read port of the run time ram, and
// the input stays closed from the acceptance of a quantum until its last row has been
// taken by the output register, and longer while the result stream stalls. One
// finished row waits in the output register while the next scan runs. Reset needs no
// clearing pass; reading a slot never loaded gives undefined rows.
//
// depends on lfqs_pkg, lfqs_ram, lfqs_sched, lfqs_outreg and the assertion macro header
`include "largest_fit_quantum_scheduler_top_macros.svh"

module largest_fit_quantum_scheduler_top #(
  parameter int MAX_PROCESSES = 16,
  parameter int TIME_BITS     = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot, run_length, quantum
  input  logic [lfqs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                             in_tuser,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // process_number, process_time, budget, remaining, all_done, zero pad
  output logic [lfqs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // selected
  output logic                             out_tuser,
  output logic                             out_tlast,
  // num_processes register
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfqs_pkg::NUM_W-1:0]       cfg_data
);

  localparam int IDXW = $clog2(MAX_PROCESSES);

  logic                        mem_we;
  logic [IDXW-1:0]             mem_waddr;
  logic [TIME_BITS-1:0]        mem_wdata;
  logic                        mem_re;
  logic [IDXW-1:0]             mem_raddr;
  logic [TIME_BITS-1:0]        mem_rdata;
  logic                        row_valid;
  logic                        row_ready;
  lfqs_pkg::lfqs_row_t         row;
  logic [lfqs_pkg::SLOT_W-1:0] in_slot;
  logic [lfqs_pkg::LEN_W-1:0]  in_run_length;
  logic [lfqs_pkg::QNT_W-1:0]  in_quantum;
  logic                        q_take;
  logic                        idle_row_ok;
  logic                        pick_ok;
  logic                        done_pick;

  // input unpacking
  assign in_slot       = in_tdata[lfqs_pkg::SLOT_W-1:0];
  assign in_run_length = in_tdata[lfqs_pkg::SLOT_W +: lfqs_pkg::LEN_W];
  assign in_quantum    = in_tdata[lfqs_pkg::SLOT_W + lfqs_pkg::LEN_W +: lfqs_pkg::QNT_W];

  assign cfg_ready = 1'b1;

  // run time table
  lfqs_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_PROCESSES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // scheduling engine
  lfqs_sched #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_BITS     (TIME_BITS)
  ) u_sched (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser),
    .in_slot       (in_slot),
    .in_run_length (in_run_length),
    .in_quantum    (in_quantum),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .row_valid     (row_valid),
    .row_ready     (row_ready),
    .row           (row)
  );

  // result register
  lfqs_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row        (row),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // terms used by the checks
  assign q_take      = in_tvalid && in_tready && (in_tuser == lfqs_pkg::FUNC_QUANTUM);
  assign idle_row_ok = row.last && (row.remaining == row.budget) && (row.process_number == '0);
  assign pick_ok     = (row.process_time != '0) && (row.remaining < row.budget);
  assign done_pick   = row_valid && row.selected && row.all_done;

  // a quantum closes the input until its rows are done
  `LFQS_ASSERT(a_quantum_blocks, clk, rst_n, q_take |=> !in_tready, "input open after a quantum")
  // an idle row ends the quantum and keeps the budget
  `LFQS_ASSERT_ALWAYS(a_idle_row, clk, (row_valid && !row.selected) |-> idle_row_ok, "bad idle row")
  // a pick always spends time it had
  `LFQS_ASSERT_ALWAYS(a_pick_spends, clk, (row_valid && row.selected) |-> pick_ok, "pick over budget")
  // finishing every process ends the quantum
  `LFQS_ASSERT_ALWAYS(a_done_last, clk, done_pick |-> row.last, "all done without last")

endmodule
